[rtl/core/s2x_pkg.sv]
// s2x_pkg: shared widths, types and register codes of the scale2x upscaler core
// no dependencies; used by the channel interfaces, the line buffer and the top level
`default_nettype none

package s2x_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W = 32;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  localparam int CFGW_W     = 11;
  localparam int CFGH_W     = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_ADDR_W = 2;

  localparam int W_RESET = 1024;
  localparam int H_RESET = 768;

  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic [COL_W-1:0]      col_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [CFGW_W-1:0]     cfgw_t;
  typedef logic [CFGH_W-1:0]     cfgh_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // configuration register indexes
  localparam cfg_addr_t CFG_FRAME_WIDTH  = cfg_addr_t'(0);
  localparam cfg_addr_t CFG_FRAME_HEIGHT = cfg_addr_t'(1);

  // one line buffer entry: row above and two rows above at one column
  typedef struct packed {
    pix_t curr;
    pix_t prev;
  } entry_t;

  // top level to line buffer
  typedef struct packed {
    logic rd_en;
    col_t rd_addr;
    logic rd_self;
    logic commit;
    col_t wr_addr;
    pix_t wr_pix;
  } lb_ctrl_t;

  // neighborhood around the item in the work stage
  typedef struct packed {
    pix_t up_m1;
    pix_t up_0;
    pix_t up_p1;
    pix_t up2_0;
    pix_t pix_m1;
    pix_t pix_m2;
  } lb_win_t;

endpackage

`default_nettype wire

[rtl/core/s2x_if.sv]
// s2x channel interfaces: pixel input, result output and configuration write
// depends on s2x_pkg for field widths
`default_nettype none

interface s2x_in_if;
  logic               valid;
  logic               ready;
  s2x_pkg::pix_t      pixel_in;

  modport source(output valid, output pixel_in, input ready);
  modport sink(input valid, input pixel_in, output ready);
endinterface

interface s2x_out_if;
  logic               valid;
  logic               ready;
  s2x_pkg::pix_t      out_top_left;
  s2x_pkg::pix_t      out_top_right;
  s2x_pkg::pix_t      out_bottom_left;
  s2x_pkg::pix_t      out_bottom_right;
  s2x_pkg::row_t      src_row;
  s2x_pkg::col_t      src_col;
  logic               frame_last;

  modport source(output valid, output out_top_left, output out_top_right,
                 output out_bottom_left, output out_bottom_right, output src_row,
                 output src_col, output frame_last, input ready);
  modport sink(input valid, input out_top_left, input out_top_right,
               input out_bottom_left, input out_bottom_right, input src_row,
               input src_col, input frame_last, output ready);
endinterface

interface s2x_cfg_if;
  logic                valid;
  logic                ready;
  s2x_pkg::cfg_addr_t  addr;
  s2x_pkg::cfg_data_t  data;

  modport source(output valid, output addr, output data, input ready);
  modport sink(input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/s2x_line_buf.sv]
// s2x_line_buf: line memory holding the two rows above, read one column ahead,
// written back on commit, with forwarding and the neighborhood window; uses s2x_pkg
`default_nettype none

module s2x_line_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  s2x_pkg::lb_ctrl_t ctrl,
  output s2x_pkg::lb_win_t  win
);

  s2x_pkg::entry_t mem [s2x_pkg::MAX_WIDTH];
  s2x_pkg::entry_t mem_q_r;

  logic            fwd_hit_r;
  logic            self_r;
  s2x_pkg::entry_t fwd_data_r;

  s2x_pkg::pix_t   up_m1_r;
  s2x_pkg::pix_t   up_0_r;
  s2x_pkg::pix_t   up2_0_r;
  s2x_pkg::pix_t   pix_m1_r;
  s2x_pkg::pix_t   pix_m2_r;

  s2x_pkg::entry_t wr_ent;
  s2x_pkg::entry_t nxt_ent;

  // write data of the item in the work stage: its pixel over the row above
  assign wr_ent = '{curr: ctrl.wr_pix, prev: up_0_r};

  // width one: the item reads back its own column
  always_comb begin
    priority if (self_r) begin
      nxt_ent = wr_ent;
    end else if (fwd_hit_r) begin
      nxt_ent = fwd_data_r;
    end else begin
      nxt_ent = mem_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      mem[ctrl.wr_addr] <= wr_ent;
    end
    if (ctrl.rd_en) begin
      mem_q_r <= mem[ctrl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
      self_r    <= 1'b0;
    end else if (ctrl.rd_en) begin
      fwd_hit_r <= ctrl.commit && (ctrl.wr_addr == ctrl.rd_addr);
      self_r    <= ctrl.rd_self;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      fwd_data_r <= wr_ent;
    end
    if (ctrl.commit) begin
      up_m1_r  <= up_0_r;
      up_0_r   <= nxt_ent.curr;
      up2_0_r  <= nxt_ent.prev;
      pix_m2_r <= pix_m1_r;
      pix_m1_r <= ctrl.wr_pix;
    end
  end

  assign win = '{up_m1: up_m1_r, up_0: up_0_r, up_p1: nxt_ent.curr, up2_0: up2_0_r,
                 pix_m1: pix_m1_r, pix_m2: pix_m2_r};

endmodule

`default_nettype wire

[rtl/core/scale2x_pixel_upscaler_core.sv]
// scale2x_pixel_upscaler_core: streaming scale2x over a raster frame of 32-bit pixels
// depends on s2x_pkg, the s2x channel interfaces and s2x_line_buf
//
//   channel  dir  handshake      payload
//   cfg_ch   in   valid/ready    addr (0 width, 1 height), data
//   in_ch    in   valid/ready    pixel_in
//   out_ch   out  valid/ready    four output pixels, src_row, src_col, frame_last
//
// one item per cycle while each item releases at most one result and the output is not
// stalled; one result leaves per cycle through the single result register, so on the last
// row of a frame taller than one row an item past column zero releases two results and the
// final item three. an item is held in the work stage and its results pass through the result register.
// synchronous reset sets 1024 x 768 and empties the pipe; the line memory is not
// cleared. a stalled output holds; items are still taken into the work stage until one has a result pending.
`default_nettype none

module scale2x_pixel_upscaler_core (
  input  logic        clk,
  input  logic        rst_n,
  s2x_cfg_if.sink     cfg_ch,
  s2x_in_if.sink      in_ch,
  s2x_out_if.source   out_ch
);

  typedef struct packed {
    s2x_pkg::pix_t tl;
    s2x_pkg::pix_t tr;
    s2x_pkg::pix_t bl;
    s2x_pkg::pix_t br;
    s2x_pkg::row_t row;
    s2x_pkg::col_t col;
    logic          last;
  } res_t;

  typedef struct packed {
    s2x_pkg::pix_t b;
    s2x_pkg::pix_t d;
    s2x_pkg::pix_t e;
    s2x_pkg::pix_t f;
    s2x_pkg::pix_t h;
  } nbr_t;

  function automatic res_t scale_kernel(nbr_t n, s2x_pkg::row_t row, s2x_pkg::col_t col,
                                        logic last);
    res_t q;
    q = '{tl: n.e, tr: n.e, bl: n.e, br: n.e, row: row, col: col, last: last};
    if (n.b != n.h && n.d != n.f) begin
      q.tl = (n.d == n.b) ? n.d : n.e;
      q.tr = (n.b == n.f) ? n.f : n.e;
      q.bl = (n.d == n.h) ? n.d : n.e;
      q.br = (n.h == n.f) ? n.f : n.e;
    end
    return q;
  endfunction

  // configuration, kept as last index
  s2x_pkg::col_t w_m1_r, w_m1_nxt;
  s2x_pkg::row_t h_m1_r, h_m1_nxt;
  s2x_pkg::cfgw_t wdat;
  s2x_pkg::cfgh_t hdat;
  logic cfg_wr;

  // position of the next item
  s2x_pkg::row_t row_cnt_r, row_cnt_nxt;
  s2x_pkg::col_t col_cnt_r, col_cnt_nxt;
  logic last_col, last_row;
  logic acc;
  logic in_ready;

  // work stage
  logic          s1_valid_r;
  logic [2:0]    s1_pend_r, s1_pend_nxt, pend_after;
  s2x_pkg::pix_t s1_p_r;
  s2x_pkg::row_t s1_r_r;
  s2x_pkg::col_t s1_c_r;
  logic          s1_last_row_r, s1_last_col_r, s1_r_zero_r, s1_r_one_r;
  logic          s1_c_zero_r, s1_c_ge2_r;
  logic          s1_done;
  logic          emit_go;
  logic          slot_free;

  // output register
  logic out_valid_r;
  res_t out_res_r;
  res_t res;
  nbr_t nbr;
  s2x_pkg::row_t res_row;
  s2x_pkg::col_t res_col;
  logic          res_last;

  s2x_pkg::lb_ctrl_t lb_ctrl;
  s2x_pkg::lb_win_t  win;

  // ---------------- configuration ----------------
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr = cfg_ch.valid &&
                  (cfg_ch.addr == s2x_pkg::CFG_FRAME_WIDTH ||
                   cfg_ch.addr == s2x_pkg::CFG_FRAME_HEIGHT);
  assign wdat = cfg_ch.data[s2x_pkg::CFGW_W-1:0];
  assign hdat = cfg_ch.data[s2x_pkg::CFGH_W-1:0];

  always_comb begin
    w_m1_nxt = w_m1_r;
    h_m1_nxt = h_m1_r;
    if (cfg_ch.valid && cfg_ch.addr == s2x_pkg::CFG_FRAME_WIDTH) begin
      if (wdat == '0) begin
        w_m1_nxt = '0;
      end else if (wdat > s2x_pkg::cfgw_t'(s2x_pkg::MAX_WIDTH)) begin
        w_m1_nxt = s2x_pkg::col_t'(s2x_pkg::MAX_WIDTH - 1);
      end else begin
        w_m1_nxt = s2x_pkg::col_t'(wdat - s2x_pkg::cfgw_t'(1));
      end
    end
    if (cfg_ch.valid && cfg_ch.addr == s2x_pkg::CFG_FRAME_HEIGHT) begin
      if (hdat == '0) begin
        h_m1_nxt = '0;
      end else if (hdat > s2x_pkg::cfgh_t'(s2x_pkg::MAX_HEIGHT)) begin
        h_m1_nxt = s2x_pkg::row_t'(s2x_pkg::MAX_HEIGHT - 1);
      end else begin
        h_m1_nxt = s2x_pkg::row_t'(hdat - s2x_pkg::cfgh_t'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r <= s2x_pkg::col_t'(s2x_pkg::W_RESET - 1);
      h_m1_r <= s2x_pkg::row_t'(s2x_pkg::H_RESET - 1);
    end else begin
      w_m1_r <= w_m1_nxt;
      h_m1_r <= h_m1_nxt;
    end
  end

  // ---------------- input side and position ----------------
  assign last_col = (col_cnt_r == w_m1_r);
  assign last_row = (row_cnt_r == h_m1_r);
  assign in_ready = !s1_valid_r || s1_done;
  assign in_ch.ready = in_ready;
  assign acc = in_ch.valid && in_ready;

  always_comb begin
    row_cnt_nxt = row_cnt_r;
    col_cnt_nxt = col_cnt_r;
    priority if (cfg_wr) begin
      row_cnt_nxt = '0;
      col_cnt_nxt = '0;
    end else if (acc) begin
      if (last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_row ? '0 : row_cnt_r + s2x_pkg::row_t'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + s2x_pkg::col_t'(1);
      end
    end else begin
      row_cnt_nxt = row_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else begin
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
    end
  end

  // ---------------- line buffer ----------------
  always_comb begin
    lb_ctrl.rd_en   = acc;
    lb_ctrl.rd_addr = last_col ? '0 : col_cnt_r + s2x_pkg::col_t'(1);
    lb_ctrl.rd_self = (lb_ctrl.rd_addr == col_cnt_r);
    lb_ctrl.commit  = s1_done;
    lb_ctrl.wr_addr = s1_c_r;
    lb_ctrl.wr_pix  = s1_p_r;
  end

  s2x_line_buf u_line_buf (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (lb_ctrl),
    .win   (win)
  );

  // ---------------- work stage ----------------
  // pending results: bit 0 pixel above, bit 1 pixel to the left, bit 2 the item itself
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign emit_go    = s1_valid_r && (s1_pend_r != '0) && slot_free;
  assign pend_after = s1_pend_r & (s1_pend_r - 3'd1);
  assign s1_done    = s1_valid_r && ((s1_pend_r == '0) || (emit_go && pend_after == '0));

  always_comb begin
    priority if (s1_pend_r[0]) begin
      nbr.e    = win.up_0;
      nbr.b    = s1_r_one_r ? win.up_0 : win.up2_0;
      nbr.d    = s1_c_zero_r ? win.up_0 : win.up_m1;
      nbr.f    = s1_last_col_r ? win.up_0 : win.up_p1;
      nbr.h    = s1_p_r;
      res_row  = s1_r_r - s2x_pkg::row_t'(1);
      res_col  = s1_c_r;
      res_last = 1'b0;
    end else if (s1_pend_r[1]) begin
      nbr.e    = win.pix_m1;
      nbr.b    = s1_r_zero_r ? win.pix_m1 : win.up_m1;
      nbr.d    = s1_c_ge2_r ? win.pix_m2 : win.pix_m1;
      nbr.f    = s1_p_r;
      nbr.h    = win.pix_m1;
      res_row  = s1_r_r;
      res_col  = s1_c_r - s2x_pkg::col_t'(1);
      res_last = 1'b0;
    end else begin
      nbr.e    = s1_p_r;
      nbr.b    = s1_r_zero_r ? s1_p_r : win.up_0;
      nbr.d    = s1_c_zero_r ? s1_p_r : win.pix_m1;
      nbr.f    = s1_p_r;
      nbr.h    = s1_p_r;
      res_row  = s1_r_r;
      res_col  = s1_c_r;
      res_last = 1'b1;
    end
  end

  assign res = scale_kernel(nbr, res_row, res_col, res_last);

  always_comb begin
    s1_pend_nxt = s1_pend_r;
    priority if (acc) begin
      s1_pend_nxt = {last_row && last_col, last_row && (col_cnt_r != '0),
                     row_cnt_r != '0};
    end else if (s1_done) begin
      s1_pend_nxt = '0;
    end else if (emit_go) begin
      s1_pend_nxt = pend_after;
    end else begin
      s1_pend_nxt = s1_pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_pend_r  <= '0;
    end else begin
      s1_pend_r <= s1_pend_nxt;
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_p_r        <= in_ch.pixel_in;
      s1_r_r        <= row_cnt_r;
      s1_c_r        <= col_cnt_r;
      s1_last_row_r <= last_row;
      s1_last_col_r <= last_col;
      s1_r_zero_r   <= (row_cnt_r == '0);
      s1_r_one_r    <= (row_cnt_r == s2x_pkg::row_t'(1));
      s1_c_zero_r   <= (col_cnt_r == '0);
      s1_c_ge2_r    <= (col_cnt_r > s2x_pkg::col_t'(1));
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.out_top_left     = out_res_r.tl;
  assign out_ch.out_top_right    = out_res_r.tr;
  assign out_ch.out_bottom_left  = out_res_r.bl;
  assign out_ch.out_bottom_right = out_res_r.br;
  assign out_ch.src_row          = out_res_r.row;
  assign out_ch.src_col          = out_res_r.col;
  assign out_ch.frame_last       = out_res_r.last;

  // ---------------- assertions ----------------
  a_pend_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_pend_r != '0) |-> s1_valid_r)
    else $error("results pending with no item in the work stage");

  a_item_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> s1_valid_r && (s1_p_r == $past(in_ch.pixel_in)))
    else $error("accepted item not held in the work stage");

  a_self_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_pend_r[2]) |-> (s1_last_row_r && s1_last_col_r))
    else $error("final result pending away from the frame end");

  a_last_row_only: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_last_row_r) |-> (s1_pend_r[1] == 1'b0 && s1_pend_r[2] == 1'b0))
    else $error("same-row result pending before the last row");

endmodule

`default_nettype wire

[tb/scale2x_pixel_upscaler_core_checker.sv]
// scale2x_pixel_upscaler_core_checker: watches the cfg, pixel and result channels of the core,
// predicts every 2x2 output block from the accepted pixels and compares in arrival order
// depends on s2x_pkg and the s2x channel interfaces
module scale2x_pixel_upscaler_core_checker
  import s2x_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  s2x_cfg_if   cfg_ch,
  s2x_in_if    in_ch,
  s2x_out_if   out_ch,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    pix_t tl;
    pix_t tr;
    pix_t bl;
    pix_t br;
    row_t row;
    col_t col;
    logic last;
  } block_t;

  cfgw_t  width_reg;
  cfgh_t  height_reg;
  // near_line: current row left of the column, row above from it on; far_line one row higher
  pix_t   near_line [MAX_WIDTH];
  pix_t   far_line [MAX_WIDTH];
  int     row_pos;
  int     col_pos;
  pix_t   left_pix;
  block_t blocks_due [$];

  task automatic flag(input string msg);
    if (errors < 40) $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) flag($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic block_t scale_block(pix_t b, pix_t d, pix_t e, pix_t f, pix_t h,
                                         int row, int col, logic last);
    block_t blk;
    blk.tl   = e;
    blk.tr   = e;
    blk.bl   = e;
    blk.br   = e;
    if (b != h && d != f) begin
      blk.tl = (d == b) ? d : e;
      blk.tr = (b == f) ? f : e;
      blk.bl = (d == h) ? d : e;
      blk.br = (h == f) ? f : e;
    end
    blk.row  = row_t'(row);
    blk.col  = col_t'(col);
    blk.last = last;
    return blk;
  endfunction

  task automatic apply_cfg(input cfg_addr_t addr, input cfg_data_t data);
    case (addr)
      CFG_FRAME_WIDTH: begin
        width_reg = cfgw_t'(data);
        row_pos   = 0;
        col_pos   = 0;
      end
      CFG_FRAME_HEIGHT: begin
        height_reg = cfgh_t'(data);
        row_pos    = 0;
        col_pos    = 0;
      end
      default: ;
    endcase
  endtask

  task automatic predict_pixel(input pix_t p);
    int   w;
    int   hgt;
    int   r;
    int   c;
    logic last_row;
    logic last_col;
    pix_t e;
    pix_t b;
    pix_t d;
    pix_t f;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
    hgt = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
    r = row_pos;
    c = col_pos;
    last_row = (r >= hgt - 1);
    last_col = (c >= w - 1);
    // this pixel is the lower neighbor of the one above it
    if (r >= 1) begin
      e = near_line[c];
      b = (r == 1) ? e : far_line[c];
      d = (c == 0) ? e : far_line[c-1];
      f = last_col ? e : near_line[c+1];
      blocks_due.push_back(scale_block(b, d, e, f, p, r - 1, c, 1'b0));
    end
    far_line[c]  = near_line[c];
    near_line[c] = p;
    if (last_row) begin
      // bottom row: the left pixel now has its right neighbor
      if (c >= 1) begin
        b = (r == 0) ? left_pix : far_line[c-1];
        d = (c >= 2) ? near_line[c-2] : left_pix;
        blocks_due.push_back(scale_block(b, d, left_pix, p, left_pix, r, c - 1, 1'b0));
      end
      if (last_col) begin
        b = (r == 0) ? p : far_line[c];
        d = (c >= 1) ? near_line[c-1] : p;
        blocks_due.push_back(scale_block(b, d, p, p, p, r, c, 1'b1));
      end
    end
    left_pix = p;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_block();
    block_t want;
    if (blocks_due.size() == 0) begin
      flag($sformatf("result for row %0d col %0d with none expected",
                     out_ch.src_row, out_ch.src_col));
      return;
    end
    want = blocks_due.pop_front();
    cmp_field("out_top_left", out_ch.out_top_left, want.tl);
    cmp_field("out_top_right", out_ch.out_top_right, want.tr);
    cmp_field("out_bottom_left", out_ch.out_bottom_left, want.bl);
    cmp_field("out_bottom_right", out_ch.out_bottom_right, want.br);
    cmp_field("src_row", 32'(out_ch.src_row), 32'(want.row));
    cmp_field("src_col", 32'(out_ch.src_col), 32'(want.col));
    cmp_field("frame_last", 32'(out_ch.frame_last), 32'(want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = cfgw_t'(W_RESET);
      height_reg = cfgh_t'(H_RESET);
      foreach (near_line[i]) begin
        near_line[i] = '0;
        far_line[i]  = '0;
      end
      row_pos  = 0;
      col_pos  = 0;
      left_pix = '0;
      blocks_due.delete();
      errors   = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) apply_cfg(cfg_ch.addr, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) predict_pixel(in_ch.pixel_in);
      if (out_ch.valid && out_ch.ready) check_block();
    end
    pending = blocks_due.size();
  end

endmodule

[tb/scale2x_pixel_upscaler_core_tb.sv]
// scale2x_pixel_upscaler_core_tb: drives frames of pixels and register writes into the core,
// paces the result channel and gives the verdict from the checker's counts
// depends on s2x_pkg, the s2x channel interfaces, the core and its checker
module scale2x_pixel_upscaler_core_tb;
  import s2x_pkg::*;

  localparam cfg_addr_t CFG_UNUSED   = cfg_addr_t'(2);
  localparam int        SETTLE       = 16;
  localparam int        STALL_LIMIT  = 1000;
  localparam int        RANDOM_ITEMS = 220;

  logic clk = 1'b0;
  logic rst_n;
  int   errors;
  int   pending;
  int   quiet_cycles = 0;
  logic burst = 1'b0;
  int   cur_w;
  int   cur_h;
  pix_t palette [4];
  int   palette_n;

  s2x_cfg_if cfg_ch();
  s2x_in_if  in_ch();
  s2x_out_if out_ch();

  scale2x_pixel_upscaler_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  scale2x_pixel_upscaler_core_checker check_u (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  always #4 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(12, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic int clamp_size(int raw, int top_size);
    if (raw == 0) return 1;
    return (raw > top_size) ? top_size : raw;
  endfunction

  function automatic pix_t next_pixel();
    if (palette_n == 0) return $urandom;
    return palette[$urandom_range(0, palette_n - 1)];
  endfunction

  task automatic new_palette();
    // few colors so that neighbors often match
    palette_n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(2, 4);
    foreach (palette[i]) palette[i] = $urandom;
  endtask

  task automatic send_pixel(input pix_t p);
    int gap;
    gap = burst ? 0 : gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.pixel_in <= p;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_pixels(input int n);
    repeat (n) send_pixel(next_pixel());
  endtask

  // drain every expected result, then let items still in the pipe settle
  task automatic idle_wait();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_addr_t addr, input int data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= addr;
    cfg_ch.data  <= cfg_data_t'(data);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reframe(input int w, input int h);
    idle_wait();
    cfg_write(CFG_FRAME_WIDTH, w);
    cfg_write(CFG_FRAME_HEIGHT, h);
    cur_w = clamp_size(w & 'h7FF, MAX_WIDTH);
    cur_h = clamp_size(h & 'h1FFF, MAX_HEIGHT);
  endtask

  // result side: stretches always ready, otherwise random stalls
  initial begin : sink_pace
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    pix_t grid [9];
    int   random_sent;
    int   w;
    int   h;
    int   n;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.pixel_in = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.addr    = CFG_FRAME_WIDTH;
    cfg_ch.data    = '0;
    cur_w          = W_RESET;
    cur_h          = H_RESET;
    palette_n      = 0;
    random_sent    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero sizes act as 1x1: every item is a whole frame
    reframe(0, 0);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0000);

    // 3x3 with a center whose top-left and bottom-right corners take the matching neighbors
    grid = '{32'h0, 32'h1, 32'h0,
             32'h1, 32'hFFFF_FFFF, 32'h2,
             32'h0, 32'h2, 32'h0};
    reframe(3, 3);
    foreach (grid[i]) send_pixel(grid[i]);

    // single column and single row
    reframe(1, 3);
    send_pixel(32'h7);
    send_pixel(32'h7);
    send_pixel(32'h9);
    reframe(4, 1);
    send_pixel(32'h3);
    send_pixel(32'h3);
    send_pixel(32'h4);
    send_pixel(32'h3);

    // frame cut short by a register write, then a write to an unused index mid-frame
    reframe(3, 2);
    foreach (grid[i]) if (i < 4) send_pixel(grid[i] ^ 32'h5A5A_0000);
    reframe(2, 2);
    send_pixel(32'hA);
    send_pixel(32'hB);
    idle_wait();
    cfg_write(CFG_UNUSED, 'h1FFF);
    send_pixel(32'hB);
    send_pixel(32'hA);

    // oversized width saturates to the full line; only the start of it is sent
    new_palette();
    reframe('h1FFF, 2);
    send_pixels(12);
    // oversized height saturates; the top of a tall frame one pixel wide
    new_palette();
    burst = 1'b1;
    reframe(1, 'h1FFF);
    send_pixels(12);

    while (random_sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 2) == 0);
      new_palette();
      if (cur_w * cur_h > 64 || $urandom_range(0, 3) != 0) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        h = $urandom_range(0, 6);
        if (cur_w * cur_h <= 64 && $urandom_range(0, 3) == 0) begin
          // touch one register only
          idle_wait();
          if ($urandom_range(0, 1) == 1) begin
            cfg_write(CFG_FRAME_WIDTH, w);
            cur_w = clamp_size(w, MAX_WIDTH);
          end else begin
            cfg_write(CFG_FRAME_HEIGHT, h);
            cur_h = clamp_size(h, MAX_HEIGHT);
          end
        end else begin
          reframe(w, h);
        end
      end
      n = cur_w * cur_h;
      if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
      send_pixels(n);
      random_sent += n;
    end

    idle_wait();
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
